// ===== rtl/csem_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the counting semaphore table.
// Depends on nothing; used by counting_semaphore_table.
package csem_pkg;

   localparam int unsigned NUM_SEMS_DEF    = 16;
   localparam int unsigned QUEUE_DEPTH_DEF = 16;
   localparam int unsigned PID_BITS_DEF    = 8;
   localparam int unsigned COUNT_BITS_DEF  = 16;

   localparam logic [1:0] OP_INIT    = 2'd0;
   localparam logic [1:0] OP_WAIT    = 2'd1;
   localparam logic [1:0] OP_POST    = 2'd2;
   localparam logic [1:0] OP_DESTROY = 2'd3;

   localparam logic [2:0] STATUS_DONE    = 3'd0;
   localparam logic [2:0] STATUS_REFUSED = 3'd1;
   localparam logic [2:0] STATUS_BLOCKED = 3'd2;
   localparam logic [2:0] STATUS_WOKEN   = 3'd3;
   localparam logic [2:0] STATUS_FULL    = 3'd4;

   typedef struct packed {
      logic [1:0]  operation;
      logic [3:0]  sem_index;
      logic [15:0] initial_count;
      logic [7:0]  process_id;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  woken_pid;
      logic [15:0] count_after;
   } rsp_type;

endpackage

// ===== rtl/counting_semaphore_table.sv =====
`timescale 1ns / 1ps
// Counting semaphore table with per-entry FIFO wait queues.
// Depends on csem_pkg for the item types, operation codes and status codes.
//
// An item is taken when start is high and busy is low; its result appears on
// rsp_item for exactly one cycle with rsp_valid high, and the receiver cannot
// stall it. Init, wait, destroy and a post without a waiter read the
// semaphore entry from its memory and then write it back (destroy only
// clears its present bit). A post that wakes a waiter also reads the waiter
// id from the queue memory, at the head pointer found in the entry read,
// before the write-back. No new item is taken until the write-back is done,
// so reads never see stale entries. No clearing pass is needed after reset.
module counting_semaphore_table #(
   parameter int unsigned NUM_SEMS    = csem_pkg::NUM_SEMS_DEF,
   parameter int unsigned QUEUE_DEPTH = csem_pkg::QUEUE_DEPTH_DEF,
   parameter int unsigned PID_BITS    = csem_pkg::PID_BITS_DEF,
   parameter int unsigned COUNT_BITS  = csem_pkg::COUNT_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  csem_pkg::req_type req_item,
   output logic              rsp_valid,
   output csem_pkg::rsp_type rsp_item
);
   import csem_pkg::*;

   localparam int unsigned SEM_BITS   = $clog2(NUM_SEMS);
   localparam int unsigned QB         = $clog2(QUEUE_DEPTH);
   localparam int unsigned FB         = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned ENTRY_BITS = COUNT_BITS + 2 * QB + FB;
   localparam int unsigned WAIT_DEPTH = NUM_SEMS << QB;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [QB-1:0]         LAST_SLOT = QB'(QUEUE_DEPTH - 1);
   localparam logic [FB-1:0]         FILL_FULL = FB'(QUEUE_DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_ENTRY = 3'b010,
      ST_WAKE  = 3'b100
   } state_type;

   state_type               state_ff, state_in;
   req_type                 req_ff;
   logic [NUM_SEMS-1:0]     present_ff, present_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_item_ff, rsp_item_in;

   logic [ENTRY_BITS-1:0]   entry_mem [NUM_SEMS];
   logic [PID_BITS-1:0]     waiter_mem [WAIT_DEPTH];
   logic [ENTRY_BITS-1:0]   entry_rd_ff;
   logic [PID_BITS-1:0]     waiter_rd_ff;

   logic                    accept;
   logic [SEM_BITS-1:0]     sem_addr;
   logic                    idx_valid;
   logic                    here;
   logic [COUNT_BITS-1:0]   rd_count;
   logic [QB-1:0]           rd_head;
   logic [QB-1:0]           rd_tail;
   logic [FB-1:0]           rd_fill;
   logic [COUNT_BITS-1:0]   new_count;
   logic [QB-1:0]           new_head;
   logic [QB-1:0]           new_tail;
   logic [FB-1:0]           new_fill;
   logic [COUNT_BITS-1:0]   init_count;
   logic [PID_BITS-1:0]     pid;
   logic [2:0]              status;
   logic [COUNT_BITS-1:0]   count_out;
   logic [PID_BITS-1:0]     woken;
   logic                    need_wake;
   logic                    finish;
   logic                    entry_we;
   logic                    waiter_we;
   logic                    waiter_re;

   assign accept   = start && (state_ff == ST_IDLE);
   assign busy     = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   assign sem_addr  = SEM_BITS'(req_ff.sem_index);
   assign idx_valid = 32'(req_ff.sem_index) < 32'(NUM_SEMS);
   assign here      = idx_valid && present_ff[sem_addr];
   assign rd_count  = entry_rd_ff[COUNT_BITS-1:0];
   assign rd_head   = entry_rd_ff[COUNT_BITS +: QB];
   assign rd_tail   = entry_rd_ff[COUNT_BITS + QB +: QB];
   assign rd_fill   = entry_rd_ff[COUNT_BITS + 2 * QB +: FB];
   assign pid       = PID_BITS'(req_ff.process_id);
   assign init_count = (32'(req_ff.initial_count) > 32'(COUNT_MAX)) ?
                       COUNT_MAX : COUNT_BITS'(req_ff.initial_count);
   assign need_wake = here && (req_ff.operation == OP_POST) && (rd_fill != '0);
   assign finish    = ((state_ff == ST_ENTRY) && !need_wake) || (state_ff == ST_WAKE);

   always_comb begin
      new_count = rd_count;
      new_head  = rd_head;
      new_tail  = rd_tail;
      new_fill  = rd_fill;
      status    = STATUS_DONE;
      count_out = '0;
      woken     = '0;
      entry_we  = 1'b0;
      waiter_we = 1'b0;
      present_in = present_ff;
      case (req_ff.operation)
         OP_INIT: begin
            if (!idx_valid) begin
               status = STATUS_REFUSED;
            end else if (here) begin
               status    = STATUS_REFUSED;
               count_out = rd_count;
            end else begin
               new_count = init_count;
               new_head  = '0;
               new_tail  = '0;
               new_fill  = '0;
               count_out = init_count;
               entry_we  = 1'b1;
               present_in[sem_addr] = 1'b1;
            end
         end
         OP_WAIT: begin
            if (here) begin
               entry_we = 1'b1;
               if (rd_count != '0) begin
                  new_count = rd_count - 1'b1;
               end else if (rd_fill == FILL_FULL) begin
                  status = STATUS_FULL;
               end else begin
                  waiter_we = 1'b1;
                  new_tail  = (rd_tail == LAST_SLOT) ? '0 : rd_tail + 1'b1;
                  new_fill  = rd_fill + 1'b1;
                  status    = STATUS_BLOCKED;
               end
               count_out = new_count;
            end
         end
         OP_POST: begin
            if (!here) begin
               status = STATUS_REFUSED;
            end else begin
               entry_we = 1'b1;
               if (rd_fill != '0) begin
                  woken    = waiter_rd_ff;
                  new_head = (rd_head == LAST_SLOT) ? '0 : rd_head + 1'b1;
                  new_fill = rd_fill - 1'b1;
                  status   = STATUS_WOKEN;
               end else if (rd_count != COUNT_MAX) begin
                  new_count = rd_count + 1'b1;
               end
               count_out = new_count;
            end
         end
         OP_DESTROY: begin
            if (!here) begin
               status = STATUS_REFUSED;
            end else begin
               present_in[sem_addr] = 1'b0;
            end
         end
         default: begin
            status = STATUS_REFUSED;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      rsp_item_in  = rsp_item_ff;
      waiter_re    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_ENTRY;
            end
         end
         ST_ENTRY: begin
            if (need_wake) begin
               waiter_re = 1'b1;
               state_in  = ST_WAKE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_WAKE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (finish) begin
         rsp_valid_in            = 1'b1;
         rsp_item_in.status      = status;
         rsp_item_in.woken_pid   = 8'(woken);
         rsp_item_in.count_after = 16'(count_out);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         present_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (finish) begin
            present_ff <= present_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
      if (accept) begin
         req_ff <= req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (finish && entry_we) begin
         entry_mem[sem_addr] <= {new_fill, new_tail, new_head, new_count};
      end
      if (accept) begin
         entry_rd_ff <= entry_mem[SEM_BITS'(req_item.sem_index)];
      end
   end

   always_ff @(posedge clock) begin
      if (finish && waiter_we) begin
         waiter_mem[{sem_addr, rd_tail}] <= pid;
      end
      if (waiter_re) begin
         waiter_rd_ff <= waiter_mem[{sem_addr, rd_head}];
      end
   end

endmodule

// ===== bench/counting_semaphore_table_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for counting_semaphore_table: directed and random items
// are checked against a behavioral copy of the semaphore table kept here.
// Depends on csem_pkg for the item types, operation codes and status codes.
module counting_semaphore_table_test;
   import csem_pkg::*;

   localparam int SETTLE_CYCLES = 8;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_valid;
   rsp_type rsp_item;

   counting_semaphore_table dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   logic        sem_live  [16];
   logic [15:0] sem_count [16];
   logic [7:0]  waiter_pid[16][16];
   logic [3:0]  wq_head   [16];
   logic [3:0]  wq_tail   [16];
   logic [4:0]  wq_fill   [16];

   rsp_type pending_results[$];
   int      mismatch_count = 0;
   int      idle_percent   = 0;

   initial clock = 1'b0;
   always #2 clock = ~clock;

   initial begin
      #2000000;
      $display("Test completed with failures");
      $finish;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatch_count < 100) begin
         $display("%0t ns: %s: got %0d, expected %0d", $realtime, what, got, want);
      end
      mismatch_count++;
   endtask

   function automatic rsp_type apply_semaphore_op(input req_type op_item);
      rsp_type    r;
      logic [3:0] s;
      r = '0;
      s = op_item.sem_index;
      case (op_item.operation)
         OP_INIT: begin
            if (sem_live[s]) begin
               r.status = STATUS_REFUSED;
               r.count_after = sem_count[s];
            end else begin
               sem_live[s] = 1'b1;
               sem_count[s] = op_item.initial_count;
               wq_head[s] = '0;
               wq_tail[s] = '0;
               wq_fill[s] = '0;
               r.count_after = op_item.initial_count;
            end
         end
         OP_WAIT: begin
            if (sem_live[s]) begin
               if (sem_count[s] != 0) begin
                  sem_count[s] = sem_count[s] - 1'b1;
               end else if (wq_fill[s] >= 5'd16) begin
                  r.status = STATUS_FULL;
               end else begin
                  waiter_pid[s][wq_tail[s]] = op_item.process_id;
                  wq_tail[s] = wq_tail[s] + 1'b1;
                  wq_fill[s] = wq_fill[s] + 1'b1;
                  r.status = STATUS_BLOCKED;
               end
               r.count_after = sem_count[s];
            end
         end
         OP_POST: begin
            if (!sem_live[s]) begin
               r.status = STATUS_REFUSED;
            end else begin
               if (wq_fill[s] != 0) begin
                  r.woken_pid = waiter_pid[s][wq_head[s]];
                  wq_head[s] = wq_head[s] + 1'b1;
                  wq_fill[s] = wq_fill[s] - 1'b1;
                  r.status = STATUS_WOKEN;
               end else if (sem_count[s] != 16'hFFFF) begin
                  sem_count[s] = sem_count[s] + 1'b1;
               end
               r.count_after = sem_count[s];
            end
         end
         OP_DESTROY: begin
            if (!sem_live[s]) begin
               r.status = STATUS_REFUSED;
            end else begin
               sem_live[s] = 1'b0;
               wq_head[s] = '0;
               wq_tail[s] = '0;
               wq_fill[s] = '0;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid !== 1'b0) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with no item pending", int'(rsp_item), 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_item.status !== want.status)
               report_mismatch("status", int'(rsp_item.status), int'(want.status));
            if (rsp_item.woken_pid !== want.woken_pid)
               report_mismatch("woken_pid", int'(rsp_item.woken_pid),
                               int'(want.woken_pid));
            if (rsp_item.count_after !== want.count_after)
               report_mismatch("count_after", int'(rsp_item.count_after),
                               int'(want.count_after));
         end
      end
   end

   task automatic send_op(input logic [1:0] operation, input logic [3:0] sem_index,
                          input logic [15:0] initial_count, input logic [7:0] process_id);
      req_type item;
      item.operation = operation;
      item.sem_index = sem_index;
      item.initial_count = initial_count;
      item.process_id = process_id;
      while ($urandom_range(99) < idle_percent) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_item <= item;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      pending_results.push_back(apply_semaphore_op(item));
   endtask

   task automatic settle_results();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_absent_entry();
      send_op(OP_WAIT, 4'd15, 16'h0000, 8'hFF);
      send_op(OP_POST, 4'd15, 16'hFFFF, 8'h00);
      send_op(OP_DESTROY, 4'd15, 16'h0000, 8'h00);
   endtask

   task automatic test_count_extremes();
      send_op(OP_INIT, 4'd15, 16'hFFFF, 8'h00);
      send_op(OP_POST, 4'd15, 16'h0000, 8'hFF);
   endtask

   task automatic test_wait_queue();
      send_op(OP_INIT, 4'd0, 16'h0000, 8'h00);
      for (int i = 0; i < 16; i++) begin
         send_op(OP_WAIT, 4'd0, 16'($urandom),
                 (i == 0) ? 8'h00 : (i == 15) ? 8'hFF : 8'($urandom));
      end
      send_op(OP_WAIT, 4'd0, 16'h0000, 8'hAA);
      send_op(OP_INIT, 4'd0, 16'h1234, 8'h55);
      send_op(OP_POST, 4'd0, 16'h0000, 8'h00);
      send_op(OP_DESTROY, 4'd0, 16'h0000, 8'h00);
   endtask

   task automatic test_random_traffic(input int item_total);
      int         sent;
      int         burst;
      int         sel;
      logic [3:0] s;
      logic [1:0] operation;
      logic [15:0] init_value;
      sent = 0;
      while (sent < item_total) begin
         sel = $urandom_range(99);
         s = ($urandom_range(99) < 80) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
         if (sel < 14) begin
            if (!sem_live[s]) begin
               send_op(OP_INIT, s, 16'h0000, 8'($urandom));
               sent++;
            end
            burst = (sel < 8) ? $urandom_range(4, 20) : $urandom_range(2, 18);
            for (int i = 0; i < burst; i++) begin
               send_op((sel < 8) ? OP_WAIT : OP_POST, s, 16'($urandom), 8'($urandom));
            end
            sent += burst;
         end else begin
            sel = $urandom_range(99);
            if (sel < 15) operation = OP_INIT;
            else if (sel < 55) operation = OP_WAIT;
            else if (sel < 92) operation = OP_POST;
            else operation = OP_DESTROY;
            sel = $urandom_range(9);
            if (sel < 6) init_value = 16'($urandom_range(2));
            else if (sel < 8) init_value = 16'hFFFF - 16'($urandom_range(1));
            else init_value = 16'($urandom);
            send_op(operation, s, init_value, 8'($urandom));
            sent++;
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      for (int i = 0; i < 16; i++) sem_live[i] = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_absent_entry();
      test_count_extremes();
      test_wait_queue();
      settle_results();

      idle_percent = 11;
      test_random_traffic(200);
      settle_results();
      idle_percent = 83;
      test_random_traffic(200);
      settle_results();
      idle_percent = 0;
      test_random_traffic(200);
      settle_results();

      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
